// ----- rtl/core/usv_pkg.sv -----
package usv_pkg;

	// Request on the byte side
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	// Request on the result side
	typedef struct packed {
		logic [20:0] code_point;
		logic        sequence_valid;
		logic [2:0]  sequence_bytes;
		logic [31:0] first_error_offset;
		logic        buffer_done;
	} result_t;

	// Classified byte, front to back
	typedef struct packed {
		logic [2:0] lead_len;
		logic       cont_ok;
		logic [5:0] low_bits;
		logic [6:0] lead_bits;
		logic       last;
	} cls_t;

	localparam logic [20:0] CP_MAX      = 21'h10FFFF;
	localparam logic [9:0]  SURR_HI     = 10'h1B;
	localparam logic [1:0]  CONT_TAG    = 2'b10;
	localparam logic [2:0]  LEN_INVALID = 3'd0;
	localparam logic [2:0]  LEN_ONE     = 3'd1;
	localparam logic [2:0]  LEN_TWO     = 3'd2;
	localparam logic [2:0]  LEN_THREE   = 3'd3;
	localparam logic [2:0]  LEN_FOUR    = 3'd4;

	// Sequence length from the top five bits of a lead byte
	function automatic logic [2:0] lead_len(input logic [4:0] top);
		logic [2:0] len;
		priority if (top[4] == 1'b0) begin
			len = LEN_ONE;
		end else if (top[4:2] == 3'b110) begin
			len = LEN_TWO;
		end else if (top[4:1] == 4'b1110) begin
			len = LEN_THREE;
		end else if (top == 5'b11110) begin
			len = LEN_FOUR;
		end else begin
			len = LEN_INVALID;
		end
		return len;
	endfunction

	// Payload bits that a lead byte contributes
	function automatic logic [6:0] lead_mask(input logic [2:0] len);
		logic [6:0] m;
		unique case (len)
			LEN_ONE:   m = 7'h7F;
			LEN_TWO:   m = 7'h1F;
			LEN_THREE: m = 7'h0F;
			LEN_FOUR:  m = 7'h07;
			default:   m = 7'h00;
		endcase
		return m;
	endfunction

	// Smallest value that is not overlong for a sequence length
	function automatic logic [20:0] min_value(input logic [2:0] len);
		logic [20:0] v;
		unique case (len)
			LEN_TWO:   v = 21'd128;
			LEN_THREE: v = 21'd2048;
			LEN_FOUR:  v = 21'd65536;
			default:   v = 21'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/core/usv_fifo.sv -----
module usv_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Hold entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- rtl/core/usv_front.sv -----
module usv_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  usv_pkg::item_t item,
	output logic           full,
	output logic           cls_push,
	output usv_pkg::cls_t  cls_data,
	input  logic           cls_full
);

	logic          v_s1;
	usv_pkg::cls_t d_s1;
	usv_pkg::cls_t cls_now;
	logic          accept;
	logic [2:0]    len;

	// Classify the incoming byte
	always_comb begin
		len               = usv_pkg::lead_len(item.data_byte[7:3]);
		cls_now.lead_len  = len;
		cls_now.cont_ok   = (item.data_byte[7:6] == usv_pkg::CONT_TAG);
		cls_now.low_bits  = item.data_byte[5:0];
		cls_now.lead_bits = item.data_byte[6:0] & usv_pkg::lead_mask(len);
		cls_now.last      = item.last_byte;
	end

	assign full     = v_s1 && cls_full;
	assign accept   = push && !full;
	assign cls_push = v_s1 && !cls_full;
	assign cls_data = d_s1;

	// Advance the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (cls_push) begin
			v_s1 <= 1'b0;
		end
	end

	// Hold the classified byte
	always_ff @(posedge clk) begin
		if (accept) begin
			d_s1 <= cls_now;
		end
	end

endmodule

// ----- rtl/core/usv_back.sv -----
module usv_back #(
	parameter int OFFSET_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cls_empty,
	input  usv_pkg::cls_t    cls_data,
	output logic             cls_pop,
	input  logic             res_full,
	output logic             res_push,
	output usv_pkg::result_t res_data
);

	localparam int OB = OFFSET_BITS;

	logic [OB-1:0] pos_q, lead_q, eoff_q;
	logic [2:0]    exp_q;
	logic [1:0]    seen_q;
	logic [20:0]   acc_q;
	logic          cbad_q, err_q;

	logic [OB-1:0] pos_n, lead_n, eoff_n;
	logic [2:0]    exp_n;
	logic [1:0]    seen_n;
	logic [20:0]   acc_n, acc_sh;
	logic          cbad_n, err_n, cbad_sh;
	logic          have, bad, fire;
	logic [20:0]   cp;
	logic          valid;
	logic [2:0]    nb;
	logic [2:0]    seen_inc;
	logic [63:0]   eoff_ext;

	assign fire    = !cls_empty && !res_full;
	assign cls_pop = fire;

	// Work out the next state for one byte
	always_comb begin
		pos_n   = (pos_q == {OB{1'b1}}) ? pos_q : pos_q + 1'b1;
		lead_n  = lead_q;
		eoff_n  = eoff_q;
		exp_n   = exp_q;
		seen_n  = seen_q;
		acc_n   = acc_q;
		cbad_n  = cbad_q;
		err_n   = err_q;
		have    = 1'b0;
		cp      = '0;
		valid   = 1'b0;
		nb      = '0;
		bad     = 1'b0;
		cbad_sh = cbad_q || !cls_data.cont_ok;
		acc_sh  = {acc_q[14:0], cls_data.low_bits};
		seen_inc = {1'b0, seen_q} + 3'd1;
		if (!err_q) begin
			if (exp_q == '0) begin
				lead_n = pos_n;
				unique case (cls_data.lead_len)
					usv_pkg::LEN_ONE: begin
						have  = 1'b1;
						cp    = {14'd0, cls_data.lead_bits};
						valid = 1'b1;
						nb    = usv_pkg::LEN_ONE;
					end
					usv_pkg::LEN_INVALID: begin
						err_n  = 1'b1;
						eoff_n = pos_n;
						have   = 1'b1;
						nb     = usv_pkg::LEN_ONE;
					end
					default: begin
						exp_n  = cls_data.lead_len;
						seen_n = 2'd1;
						acc_n  = {14'd0, cls_data.lead_bits};
						cbad_n = 1'b0;
					end
				endcase
			end else if (seen_inc >= exp_q) begin
				// Close the sequence and check its value
				bad = cbad_sh || (acc_sh < usv_pkg::min_value(exp_q))
					|| (acc_sh[20:11] == usv_pkg::SURR_HI)
					|| (acc_sh > usv_pkg::CP_MAX);
				have = 1'b1;
				nb   = exp_q;
				if (bad) begin
					err_n  = 1'b1;
					eoff_n = lead_q;
				end else begin
					cp    = acc_sh;
					valid = 1'b1;
				end
				exp_n  = '0;
				seen_n = '0;
				acc_n  = '0;
				cbad_n = 1'b0;
			end else begin
				seen_n = seen_inc[1:0];
				acc_n  = acc_sh;
				cbad_n = cbad_sh;
			end
		end
		// Latch a sequence cut off by the final byte
		if (cls_data.last && exp_n != '0 && !err_n) begin
			err_n  = 1'b1;
			eoff_n = lead_n;
		end
	end

	assign eoff_ext = 64'(eoff_n);

	// Build the result
	always_comb begin
		res_push                    = fire && (have || cls_data.last);
		res_data.code_point         = cp;
		res_data.sequence_valid     = valid;
		res_data.sequence_bytes     = nb;
		res_data.first_error_offset = (|eoff_ext[63:32]) ? 32'hFFFF_FFFF : eoff_ext[31:0];
		res_data.buffer_done        = cls_data.last;
	end

	// Advance state, clear it after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			lead_q <= '0;
			eoff_q <= '0;
			exp_q  <= '0;
			seen_q <= '0;
			acc_q  <= '0;
			cbad_q <= 1'b0;
			err_q  <= 1'b0;
		end else if (fire) begin
			if (cls_data.last) begin
				pos_q  <= '0;
				lead_q <= '0;
				eoff_q <= '0;
				exp_q  <= '0;
				seen_q <= '0;
				acc_q  <= '0;
				cbad_q <= 1'b0;
				err_q  <= 1'b0;
			end else begin
				pos_q  <= pos_n;
				lead_q <= lead_n;
				eoff_q <= eoff_n;
				exp_q  <= exp_n;
				seen_q <= seen_n;
				acc_q  <= acc_n;
				cbad_q <= cbad_n;
				err_q  <= err_n;
			end
		end
	end

endmodule

// ----- rtl/core/utf8_stream_validator_unit.sv -----
// A result reaches the result ports by way of the classify stage, the byte queue, then the
// decode step, which writes the result queue.
// Throughput: one byte per cycle without stalls; decode updates its state once per byte.
// Both sides stall independently through two-entry queues.
// Reset (arst_n low, asynchronous) empties both queues and clears the decode state.
module utf8_stream_validator_unit #(
	parameter int OFFSET_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  usv_pkg::item_t   item,
	output logic             full,
	output logic             empty,
	input  logic             pop,
	output usv_pkg::result_t result
);

	localparam int CLS_W = $bits(usv_pkg::cls_t);
	localparam int RES_W = $bits(usv_pkg::result_t);

	logic             cls_push, cls_full, cls_empty, cls_pop;
	usv_pkg::cls_t    cls_wr, cls_rd;
	logic             res_push, res_full;
	usv_pkg::result_t res_wr;
	logic [CLS_W-1:0] cls_rd_bits;
	logic [RES_W-1:0] res_rd_bits;

	usv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cls_push (cls_push),
		.cls_data (cls_wr),
		.cls_full (cls_full)
	);

	usv_fifo #(.WIDTH(CLS_W), .DEPTH(2)) u_cls_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cls_push),
		.wdata  (cls_wr),
		.full   (cls_full),
		.pop    (cls_pop),
		.rdata  (cls_rd_bits),
		.empty  (cls_empty)
	);

	assign cls_rd = usv_pkg::cls_t'(cls_rd_bits);

	usv_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_empty (cls_empty),
		.cls_data  (cls_rd),
		.cls_pop   (cls_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_wr)
	);

	usv_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wr),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rd_bits),
		.empty  (empty)
	);

	assign result = usv_pkg::result_t'(res_rd_bits);

endmodule
